// ----- design/exclusive_button_debouncer_assert.svh -----
`ifndef EXCLUSIVE_BUTTON_DEBOUNCER_ASSERT_SVH
`define EXCLUSIVE_BUTTON_DEBOUNCER_ASSERT_SVH

// same-cycle implication, reset masked
`define EBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset masked
`define EBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/ebd_pkg.sv -----
package ebd_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int SLOT_COUNT  = 8;
  localparam int LANE_COUNT  = (NUM_BUTTONS < SLOT_COUNT) ? NUM_BUTTONS : SLOT_COUNT;

  localparam int LEVELS_W   = 8;
  localparam int TICKS_W    = 32;
  localparam int DEB_W      = 16;
  localparam int BTN_W      = 3;
  localparam int IN_TDATA_W = LEVELS_W + TICKS_W;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd5;

  typedef struct packed {
    logic chg;
    logic lvl;
    logic stable;
  } lane_flag_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] stable_levels;
    logic [BTN_W-1:0]      active_button;
    logic                  active_valid;
    logic [BTN_W-1:0]      release_button;
    logic                  release_valid;
    logic [BTN_W-1:0]      press_button;
    logic                  press_valid;
  } result_t;

  localparam int RESULT_W    = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- design/ebd_lane.sv -----
module ebd_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       lvl,
  input  logic [ebd_pkg::TICKS_W-1:0] now_ticks,
  input  logic [ebd_pkg::DEB_W-1:0]   debounce_ticks,
  output ebd_pkg::lane_flag_t         flag
);
  import ebd_pkg::*;

  logic               last_raw_r;
  logic               debounced_r;
  logic [TICKS_W-1:0] change_time_r;
  logic [TICKS_W-1:0] elapsed;
  logic               held;
  logic               debounced_nxt;

  always_comb begin
    elapsed       = now_ticks - change_time_r;
    held          = (lvl == last_raw_r) && (elapsed >= TICKS_W'(debounce_ticks));
    flag.chg      = held && (lvl != debounced_r);
    flag.lvl      = lvl;
    debounced_nxt = flag.chg ? lvl : debounced_r;
    flag.stable   = debounced_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b1;
      debounced_r   <= 1'b1;
      change_time_r <= '0;
    end else if (en) begin
      if (lvl != last_raw_r) begin
        last_raw_r    <= lvl;
        change_time_r <= now_ticks;
      end
      debounced_r <= debounced_nxt;
    end
  end

endmodule

// ----- design/ebd_merge.sv -----
module ebd_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_acc,
  input  ebd_pkg::lane_flag_t [ebd_pkg::LANE_COUNT-1:0] flags,
  output logic                                   in_ready,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ebd_pkg::result_t                       out_res
);
  import ebd_pkg::*;

  logic                          s1_valid_r;
  lane_flag_t [LANE_COUNT-1:0]   s1_flags_r;
  logic                          holder_valid_r;
  logic [BTN_W-1:0]              holder_idx_r;
  logic                          out_valid_r;
  result_t                       out_res_r;

  logic                          out_adv;
  logic                          s1_adv;
  logic                          hv_nxt;
  logic [BTN_W-1:0]              hi_nxt;
  logic                          pv;
  logic [BTN_W-1:0]              pb;
  logic                          rv;
  logic [BTN_W-1:0]              rb;
  logic [SLOT_COUNT-1:0]         stable;
  result_t                       res_nxt;

  assign out_adv   = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_ready  = !s1_valid_r || out_adv;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // index-ordered claim and release of the single slot
  always_comb begin
    hv_nxt = holder_valid_r;
    hi_nxt = holder_idx_r;
    pv     = 1'b0;
    pb     = '0;
    rv     = 1'b0;
    rb     = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      if (s1_flags_r[i].chg) begin
        if (!s1_flags_r[i].lvl && !hv_nxt) begin
          hv_nxt = 1'b1;
          hi_nxt = BTN_W'(i);
          pv     = 1'b1;
          pb     = BTN_W'(i);
        end else if (s1_flags_r[i].lvl && hv_nxt && (hi_nxt == BTN_W'(i))) begin
          hv_nxt = 1'b0;
          hi_nxt = '0;
          rv     = 1'b1;
          rb     = BTN_W'(i);
        end
      end
    end
  end

  for (genvar j = 0; j < SLOT_COUNT; j++) begin : g_stable
    if (j < LANE_COUNT) begin : g_live
      assign stable[j] = s1_flags_r[j].stable;
    end else begin : g_absent
      assign stable[j] = 1'b1;
    end
  end

  always_comb begin
    res_nxt.press_valid    = pv;
    res_nxt.press_button   = pb;
    res_nxt.release_valid  = rv;
    res_nxt.release_button = rb;
    res_nxt.active_valid   = hv_nxt;
    res_nxt.active_button  = hv_nxt ? hi_nxt : '0;
    res_nxt.stable_levels  = stable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      holder_valid_r <= 1'b0;
      holder_idx_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        holder_valid_r <= hv_nxt;
        holder_idx_r   <= hi_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r <= flags;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

// ----- design/exclusive_button_debouncer.sv -----
// a taken scan is registered in stage one, then in the result register behind out_tvalid; a stall can hold it between
// throughput: one scan per cycle, no bubbles while the result side keeps tready high
// the lanes (32-bit elapsed compare) form stage one, the ordered slot merge stage two
// reset: all buttons released and stable, change times zero, no active button,
// debounce_ticks back to 5, both pipeline stages empty
module exclusive_button_debouncer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebd_pkg::DEB_W-1:0]        cfg_data,     // debounce_ticks
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // levels [7:0], now_ticks [39:8]
  input  logic [ebd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // press_valid [0], press_button [3:1], release_valid [4], release_button [7:5],
  // active_valid [8], active_button [11:9], stable_levels [19:12], zero pad [23:20]
  output logic [ebd_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ebd_pkg::*;

  logic [DEB_W-1:0]            debounce_ticks_r;
  logic                        in_acc;
  lane_flag_t [LANE_COUNT-1:0] flags;
  result_t                     res;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      debounce_ticks_r <= cfg_data;
    end
  end

  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    ebd_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .en             (in_acc),
      .lvl            (in_tdata[g]),
      .now_ticks      (in_tdata[LEVELS_W +: TICKS_W]),
      .debounce_ticks (debounce_ticks_r),
      .flag           (flags[g])
    );
  end

  ebd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .flags     (flags),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = OUT_TDATA_W'(res);

endmodule

// ----- design/ebd_checker.sv -----
`include "exclusive_button_debouncer_assert.svh"

module ebd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ebd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a press always takes the slot
  `EBD_ASSERT_NOW(a_press_holds, out_tvalid && out_tdata[0], out_tdata[8] && (out_tdata[11:9] == out_tdata[3:1]))

  // a lone release leaves the slot free
  `EBD_ASSERT_NOW(a_release_frees, out_tvalid && out_tdata[4] && !out_tdata[0], !out_tdata[8])

  // release before press within one scan
  `EBD_ASSERT_NOW(a_release_order, out_tvalid && out_tdata[4] && out_tdata[0], out_tdata[7:5] < out_tdata[3:1])

  // stalled result holds
  `EBD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind exclusive_button_debouncer ebd_checker u_ebd_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ebd_pkg::*;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DEB_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // levels [7:0], now_ticks [39:8]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // press, release, active, stable_levels

  exclusive_button_debouncer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 150;

  // model state
  logic [DEB_W-1:0]  deb_ticks = DEBOUNCE_RESET;
  logic [7:0]        raw_seen = 8'hFF;
  logic [7:0]        settled = 8'hFF;
  logic [TICKS_W-1:0] edge_stamp [8];
  logic              owner_valid = 1'b0;
  logic [BTN_W-1:0]  owner_idx = '0;

  logic [IN_TDATA_W-1:0] scan_q [$];
  result_t               due_events_q [$];

  int   errors = 0;
  int   stall_cycles = 0;
  bit   in_taken = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  bit   in_idle_on = 1'b0;
  bit   out_idle_on = 1'b0;
  int   hold_reqs = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  logic [7:0]         intent = 8'hFF;
  logic [TICKS_W-1:0] tick_now = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 8; i++) edge_stamp[i] = '0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 30));
    return int'($urandom_range(0, 3));
  endfunction

  function automatic result_t debounce_scan(logic [7:0] lv, logic [TICKS_W-1:0] now);
    result_t r;
    logic [TICKS_W-1:0] held;
    r = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      held = now - edge_stamp[i];
      if (lv[i] != raw_seen[i]) begin
        raw_seen[i] = lv[i];
        edge_stamp[i] = now;
      end else if (held >= TICKS_W'(deb_ticks) && lv[i] != settled[i]) begin
        settled[i] = lv[i];
        if (!lv[i] && !owner_valid) begin
          owner_valid = 1'b1;
          owner_idx = BTN_W'(i);
          r.press_valid = 1'b1;
          r.press_button = BTN_W'(i);
        end else if (lv[i] && owner_valid && owner_idx == BTN_W'(i)) begin
          owner_valid = 1'b0;
          owner_idx = '0;
          r.release_valid = 1'b1;
          r.release_button = BTN_W'(i);
        end
      end
    end
    r.active_valid = owner_valid;
    r.active_button = owner_valid ? owner_idx : '0;
    for (int i = 0; i < SLOT_COUNT; i++) r.stable_levels[i] = (i < LANE_COUNT) ? settled[i] : 1'b1;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // scan driver
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (scan_q.size() > 0) begin
        in_tdata <= scan_q.pop_front();
        in_tvalid <= 1'b1;
        if (in_idle_on) in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
      out_gap <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (cfg_valid && cfg_ready) deb_ticks = cfg_data;
      if (in_tvalid && in_tready)
        due_events_q.insert(due_events_q.size(),
                            debounce_scan(in_tdata[LEVELS_W-1:0],
                                          in_tdata[LEVELS_W +: TICKS_W]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[RESULT_W-1:0];
        if (due_events_q.size() == 0) begin
          $error("unexpected result %h", got);
          errors++;
        end else begin
          want = due_events_q.pop_front();
          check_field("press_valid", 32'(want.press_valid), 32'(got.press_valid));
          check_field("press_button", 32'(want.press_button), 32'(got.press_button));
          check_field("release_valid", 32'(want.release_valid), 32'(got.release_valid));
          check_field("release_button", 32'(want.release_button),
                      32'(got.release_button));
          check_field("active_valid", 32'(want.active_valid), 32'(got.active_valid));
          check_field("active_button", 32'(want.active_button), 32'(got.active_button));
          check_field("stable_levels", 32'(want.stable_levels), 32'(got.stable_levels));
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_scan(logic [7:0] lv, logic [TICKS_W-1:0] tk);
    scan_q.insert(scan_q.size(), {tk, lv});
  endtask

  task automatic queue_random_scans(int count, int unsigned step_max, int noise_pct);
    logic [7:0] raw;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_scan(8'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 5) == 0) intent[3'($urandom_range(0, 7))] ^= 1'b1;
        if ($urandom_range(0, 49) == 0) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 30);
        else tick_now += $urandom_range(0, step_max);
        raw = intent;
        if ($urandom_range(0, 99) < 15) raw[3'($urandom_range(0, 7))] ^= 1'b1;
        queue_scan(raw, tick_now);
      end
    end
  endtask

  task automatic write_debounce(logic [DEB_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle_all();
    while (scan_q.size() > 0 || in_tvalid || due_events_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed scans at the reset debounce of 5
    queue_scan(8'hFF, 32'd0);
    queue_scan(8'hFF, 32'd0);
    queue_scan(8'hFE, 32'd1);
    queue_scan(8'hFE, 32'd3);
    queue_scan(8'hFE, 32'd6);
    queue_scan(8'hFA, 32'd7);
    queue_scan(8'hFA, 32'd12);
    queue_scan(8'hFB, 32'd13);
    queue_scan(8'hFB, 32'd20);
    queue_scan(8'hDF, 32'd21);
    queue_scan(8'hDF, 32'd30);
    queue_scan(8'hFF, 32'd31);
    queue_scan(8'hFF, 32'd36);
    queue_scan(8'h7F, 32'hFFFF_FFFE);
    queue_scan(8'h7F, 32'd3);
    queue_scan(8'h00, 32'd4);
    queue_scan(8'h00, 32'hFFFF_FFFF);
    queue_scan(8'hFF, 32'h10);
    queue_scan(8'hFF, 32'h20);
    queue_scan(8'h55, 32'h7FFF_FFFF);
    queue_scan(8'hAA, 32'h8000_0000);
    queue_scan(8'hAA, 32'h8000_0005);
    queue_scan(8'hFF, 32'h8000_0006);
    settle_all();

    // zero debounce, no idling
    write_debounce(16'd0);
    tick_now = 32'd100;
    queue_random_scans(80, 2, 10);
    settle_all();

    write_debounce(16'd3);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    queue_random_scans(120, 3, 10);
    settle_all();

    write_debounce(16'hFFFF);
    queue_random_scans(60, 40000, 10);
    settle_all();

    // long receiver hold while scans keep coming
    write_debounce(16'd1);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    hold_reqs++;
    queue_random_scans(60, 2, 5);
    settle_all();

    write_debounce(16'd10);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    queue_random_scans(100, 6, 10);
    settle_all();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
